### rtl/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg: shared types and constants for the best-fit heap allocator
// Holds defaults, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package bfha_pkg;
   localparam int MAX_BLOCKS_DEF = 64;
   localparam int HEAP_BYTES_MAX_DEF = 65536;
   localparam int OFFSET_LIMIT = 65535;
   localparam logic [6:0] HDR_RESET = 7'd48;
   localparam logic [6:0] HDR_MAX = 7'd64;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_NO_FIT = 2'd1,
      ST_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_CAPACITY = 1'b0,
      CSR_HEADER = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT_UP,
      S_SPLIT,
      S_LEFT,
      S_RIGHT,
      S_SHIFT_DOWN,
      S_RESP
   } state_type;
endpackage
`default_nettype wire

### rtl/best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator: best-fit heap allocator with coalescing
// Keeps an address-ordered block table in RAM and serves allocate/free words.
// ----------------------------------------------------------------------------
// Usage. A request word (req_type, req_request_size, req_payload_offset) is
// taken on req_valid && req_ready; exactly one response word follows on the
// rsp_ channel. The block handles one request at a time: req_ready is high
// only in idle, so it is low from acceptance until the response word has
// been taken, and a stalled receiver simply holds the block.
// Timing is set by the table RAM, with one write and one read port, and the
// one shared adder. The table read is registered and a scan walks the live
// descriptors in address order; an allocate without a split then answers.
// A split first moves each descriptor above the chosen one up by one slot; a
// free merges with free neighbours and, after a merge, moves the descriptors
// above it down. The block returns to idle after each taken response word,
// before it can accept the next request.
// Reset loads capacity 65536 and header 48 and makes the table one free
// block; this needs no clearing pass, as only entries below the count are
// ever read. A csr_ write (index 0 capacity, 1 header) is taken while idle
// and reinitializes the heap the same way.
// ----------------------------------------------------------------------------
`default_nettype none
module best_fit_heap_allocator #(
   parameter int MAX_BLOCKS = bfha_pkg::MAX_BLOCKS_DEF,
   parameter int HEAP_BYTES_MAX = bfha_pkg::HEAP_BYTES_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [15:0] req_request_size,
   input  wire logic [15:0] req_payload_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_granted_offset,
   output logic [16:0]      rsp_granted_bytes,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [16:0] csr_data
);
   import bfha_pkg::*;

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int LW = $clog2(HEAP_BYTES_MAX + 1);
   localparam int XW = (LW > 17) ? LW : 17;   // width for compares with need
   localparam int EW = 2 * LW + 1;             // start, length, free flag
   localparam logic [CW-1:0] CNT_FULL = CW'(MAX_BLOCKS);
   localparam logic [LW-1:0] CAP_MAX = LW'(HEAP_BYTES_MAX);

   state_type state_ff, state_in;
   logic [LW-1:0] cap_ff, cap_in;
   logic [6:0] hdr_ff, hdr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;     // walking pointer
   logic [CW-1:0] best_ff, best_in;
   logic found_ff, found_in;
   logic op_ff, op_in;
   logic [16:0] need_ff, need_in;
   logic [15:0] off_ff, off_in;
   logic [LW-1:0] bstart_ff, bstart_in;
   logic [LW-1:0] blen_ff, blen_in;
   logic [LW-1:0] acc_ff, acc_in;     // merged length on free
   logic [LW-1:0] kstart_ff, kstart_in;
   logic [CW-1:0] keep_ff, keep_in;   // slot that survives a merge
   logic [1:0] drop_ff, drop_in;      // entries removed by a merge
   status_type status_ff, status_in;
   logic [15:0] goff_ff, goff_in;
   logic [16:0] gbytes_ff, gbytes_in;

   logic we;
   logic [AW-1:0] wa, ra;
   logic [EW-1:0] wd, rd;

   bfha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd)
   );

   // In the scan and shift states the read address follows idx, so rd holds entry idx_ff.
   logic [LW-1:0] rd_start;
   logic [LW-1:0] rd_len;
   logic rd_free;
   assign rd_start = rd[EW-1 -: LW];
   assign rd_len = rd[LW:1];
   assign rd_free = rd[0];

   // Shared adder, its operands selected by the sequencer state.
   logic [XW:0] add_a, add_b, add_q;
   assign add_q = add_a + add_b;
   always_comb begin
      case (state_ff)
         S_DECIDE: begin
            add_a = (XW+1)'(bstart_ff); add_b = (XW+1)'(hdr_ff);
         end
         S_SPLIT: begin
            add_a = (XW+1)'(bstart_ff); add_b = (XW+1)'(need_ff);
         end
         S_LEFT: begin
            add_a = (XW+1)'(blen_ff); add_b = (XW+1)'(rd_len);
         end
         S_RIGHT: begin
            add_a = (XW+1)'(acc_ff); add_b = (XW+1)'(rd_len);
         end
         default: begin
            add_a = (XW+1)'(rd_start); add_b = (XW+1)'(hdr_ff);
         end
      endcase
   end

   logic [LW-1:0] cap_w;
   logic [6:0] hdr_w;
   always_comb begin
      if (XW'(csr_data) > XW'(HEAP_BYTES_MAX)) cap_w = CAP_MAX;
      else cap_w = LW'(csr_data);
      hdr_w = csr_data[6:0];
      if (hdr_w == 7'd0) hdr_w = 7'd1;
      else if (hdr_w > HDR_MAX) hdr_w = HDR_MAX;
   end

   // Decisions shared by the next-state and datapath blocks.
   logic [CW-1:0] last_idx;
   logic at_last, cand, match, split_ok, lmerge, rmerge;
   logic [XW-1:0] rest_x;
   logic [1:0] drop_x;
   logic [CW-1:0] src0;
   logic [LW-1:0] acc_x;
   assign last_idx = count_ff - CW'(1);
   assign at_last = (idx_ff == last_idx);
   // A candidate must be free, large enough and have a 16-bit payload offset;
   // a strict compare keeps the lowest address on a tie.
   assign cand = !op_ff && rd_free && (XW'(rd_len) >= XW'(need_ff)) &&
                 (add_q <= (XW+1)'(OFFSET_LIMIT)) && (!found_ff || rd_len < blen_ff);
   assign match = op_ff && !rd_free && (add_q == (XW+1)'(off_ff));
   assign rest_x = XW'(blen_ff) - XW'(need_ff);
   assign split_ok = (rest_x > XW'(hdr_ff)) && (count_ff < CNT_FULL);
   assign lmerge = (best_ff != '0) && rd_free;
   assign rmerge = ((best_ff + CW'(1)) < count_ff) && rd_free;
   assign drop_x = drop_ff + 2'(rmerge);
   assign src0 = best_ff + CW'(rmerge) + CW'(1);
   assign acc_x = rmerge ? LW'(add_q) : acc_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_granted_offset = goff_ff;
   assign rsp_granted_bytes = gbytes_ff;
   assign rsp_status = status_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: state_in = S_IDLE;
         S_IDLE: begin
            if (csr_valid) state_in = S_INIT;
            else if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (match || at_last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!found_ff) state_in = S_RESP;
            else if (op_ff) state_in = S_LEFT;
            else if (!split_ok) state_in = S_RESP;
            else if (best_ff == last_idx) state_in = S_SPLIT;
            else state_in = S_SHIFT_UP;
         end
         S_SHIFT_UP: begin
            if (idx_ff == best_ff + CW'(1)) state_in = S_SPLIT;
         end
         S_SPLIT: state_in = S_RESP;
         S_LEFT: state_in = S_RIGHT;
         S_RIGHT: begin
            if (drop_x != 2'd0 && src0 < count_ff) state_in = S_SHIFT_DOWN;
            else state_in = S_RESP;
         end
         S_SHIFT_DOWN: begin
            if (at_last) state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   // Datapath and table RAM control.
   always_comb begin
      cap_in = cap_ff; hdr_in = hdr_ff; count_in = count_ff;
      idx_in = idx_ff; best_in = best_ff; found_in = found_ff; op_in = op_ff;
      need_in = need_ff; off_in = off_ff; bstart_in = bstart_ff;
      blen_in = blen_ff; acc_in = acc_ff; kstart_in = kstart_ff;
      keep_in = keep_ff; drop_in = drop_ff;
      status_in = status_ff; goff_in = goff_ff; gbytes_in = gbytes_ff;
      we = 1'b0; wa = '0; wd = '0; ra = AW'(idx_ff);
      case (state_ff)
         S_INIT: begin
            we = 1'b1; wa = '0; wd = {LW'(0), cap_ff, 1'b1};
            count_in = CW'(1);
         end
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_index == CSR_CAPACITY) cap_in = cap_w;
               else hdr_in = hdr_w;
            end else if (req_valid) begin
               op_in = req_type;
               need_in = 17'(req_request_size) + 17'(hdr_ff);
               off_in = req_payload_offset;
               idx_in = '0; found_in = 1'b0; ra = '0;
            end
         end
         S_SCAN: begin
            if (cand || match) begin
               found_in = 1'b1; best_in = idx_ff;
               bstart_in = rd_start; blen_in = rd_len;
            end
            if (!match && !at_last) begin
               idx_in = idx_ff + CW'(1); ra = AW'(idx_ff + CW'(1));
            end
         end
         S_DECIDE: begin
            status_in = ST_OK; goff_in = '0; gbytes_in = '0;
            if (!found_ff) begin
               status_in = op_ff ? ST_BAD_FREE : ST_NO_FIT;
            end else if (!op_ff) begin
               goff_in = 16'(add_q);
               we = 1'b1; wa = AW'(best_ff);
               if (split_ok) begin
                  // Only entries above best move, so best is final now.
                  wd = {bstart_ff, LW'(need_ff), 1'b0};
                  gbytes_in = 17'(need_ff);
                  idx_in = last_idx; ra = AW'(last_idx);
               end else begin
                  wd = {bstart_ff, blen_ff, 1'b0};
                  gbytes_in = 17'(blen_ff);
               end
            end else begin
               ra = AW'(best_ff - CW'(1));
            end
         end
         S_SHIFT_UP: begin
            we = 1'b1; wa = AW'(idx_ff + CW'(1)); wd = rd;
            if (idx_ff != best_ff + CW'(1)) begin
               idx_in = idx_ff - CW'(1); ra = AW'(idx_ff - CW'(1));
            end
         end
         S_SPLIT: begin
            we = 1'b1; wa = AW'(best_ff + CW'(1));
            wd = {LW'(add_q), LW'(rest_x), 1'b1};
            count_in = count_ff + CW'(1);
         end
         S_LEFT: begin
            if (lmerge) begin
               acc_in = LW'(add_q); kstart_in = rd_start;
               keep_in = best_ff - CW'(1);
            end else begin
               acc_in = blen_ff; kstart_in = bstart_ff; keep_in = best_ff;
            end
            drop_in = {1'b0, lmerge};
            ra = AW'(best_ff + CW'(1));
         end
         S_RIGHT: begin
            we = 1'b1; wa = AW'(keep_ff); wd = {kstart_ff, acc_x, 1'b1};
            gbytes_in = 17'(acc_x);
            drop_in = drop_x;
            if (drop_x != 2'd0) begin
               if (src0 < count_ff) begin
                  idx_in = src0; ra = AW'(src0);
               end else begin
                  count_in = count_ff - CW'(drop_x);
               end
            end
         end
         S_SHIFT_DOWN: begin
            we = 1'b1; wa = AW'(idx_ff - CW'(drop_ff)); wd = rd;
            if (at_last) begin
               count_in = count_ff - CW'(drop_ff);
            end else begin
               idx_in = idx_ff + CW'(1); ra = AW'(idx_ff + CW'(1));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cap_ff <= CAP_MAX;
         hdr_ff <= HDR_RESET;
         count_ff <= CW'(1);
         idx_ff <= '0;
         best_ff <= '0;
         found_ff <= 1'b0;
         op_ff <= 1'b0;
         need_ff <= '0;
         off_ff <= '0;
         bstart_ff <= '0;
         blen_ff <= '0;
         acc_ff <= '0;
         kstart_ff <= '0;
         keep_ff <= '0;
         drop_ff <= '0;
         status_ff <= ST_OK;
         goff_ff <= '0;
         gbytes_ff <= '0;
      end else begin
         state_ff <= state_in;
         cap_ff <= cap_in;
         hdr_ff <= hdr_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         best_ff <= best_in;
         found_ff <= found_in;
         op_ff <= op_in;
         need_ff <= need_in;
         off_ff <= off_in;
         bstart_ff <= bstart_in;
         blen_ff <= blen_in;
         acc_ff <= acc_in;
         kstart_ff <= kstart_in;
         keep_ff <= keep_in;
         drop_ff <= drop_in;
         status_ff <= status_in;
         goff_ff <= goff_in;
         gbytes_ff <= gbytes_in;
      end
   end
endmodule
`default_nettype wire

### rtl/bfha_ram.sv
// ----------------------------------------------------------------------------
// bfha_ram: generic simple dual-port RAM with registered read
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bfha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
